/* design/rmh_pkg.sv */
package rmh_pkg;

   localparam int RMH_HEAP_DEPTH = 512;
   localparam int SAMPLE_W       = 32;
   localparam int MEDIAN_W       = 33;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [MEDIAN_W-1:0] median_type;

   typedef enum logic [1:0] {
      OP_PUSH,
      OP_POP,
      OP_PUSHPOP
   } heap_op_type;

   typedef struct packed {
      logic        go;
      heap_op_type op;
      sample_type  value;
   } heap_cmd_type;

   typedef struct packed {
      logic       done;
      sample_type result;
      sample_type top;
   } heap_status_type;

   typedef enum logic [2:0] {
      H_IDLE,
      H_UP,
      H_UP_CMP,
      H_DN_LAST,
      H_DN,
      H_DN_L,
      H_DN_R
   } heap_state_type;

   typedef enum logic [2:0] {
      T_IDLE,
      T_OP1,
      T_POP,
      T_XFER,
      T_FIN
   } ctrl_state_type;

   // true when a belongs above b in the heap
   function automatic logic ranks_above(sample_type a, sample_type b, logic is_max);
      return is_max ? (a > b) : (a < b);
   endfunction

endpackage

/* design/rmh_ram.sv */
module rmh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/rmh_heap.sv */
module rmh_heap #(
   parameter int HEAP_DEPTH = rmh_pkg::RMH_HEAP_DEPTH,
   parameter bit IS_MAX     = 1'b0
) (
   input  logic                        clock,
   input  logic                        reset,
   input  rmh_pkg::heap_cmd_type       cmd,
   output rmh_pkg::heap_status_type    status,
   output logic [$clog2(HEAP_DEPTH):0] size
);
   import rmh_pkg::*;

   localparam int AW = $clog2(HEAP_DEPTH);

   heap_state_type state_ff, state_in;
   logic [AW:0]    size_ff, size_in;
   logic [AW:0]    n_ff, n_in;
   logic [AW-1:0]  idx_ff, idx_in;
   sample_type     val_ff, val_in;
   sample_type     lch_ff, lch_in;
   sample_type     res_ff, res_in;
   sample_type     top_ff;
   logic           done_ff, done_in;

   logic           wr_en, rd_en;
   logic [AW-1:0]  wr_addr, rd_addr;
   sample_type     wr_data, rd_data;

   logic [AW-1:0]  parent;
   logic [AW+1:0]  lft, rgt, n_ext;
   logic [AW:0]    last;

   assign parent = (idx_ff - 1'b1) >> 1;
   assign lft    = {1'b0, idx_ff, 1'b1};
   assign rgt    = lft + 1'b1;
   assign n_ext  = {1'b0, n_ff};
   assign last   = size_ff - 1'b1;

   rmh_ram #(.WIDTH(SAMPLE_W), .DEPTH(HEAP_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= H_IDLE;
         size_ff  <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         size_ff  <= size_in;
         done_ff  <= done_in;
      end
      n_ff   <= n_in;
      idx_ff <= idx_in;
      val_ff <= val_in;
      lch_ff <= lch_in;
      res_ff <= res_in;
      // keep a copy of the root beside the memory
      if (wr_en && wr_addr == '0) begin
         top_ff <= wr_data;
      end
   end

   always_comb begin
      state_in = state_ff;
      size_in  = size_ff;
      n_in     = n_ff;
      idx_in   = idx_ff;
      val_in   = val_ff;
      lch_in   = lch_ff;
      res_in   = res_ff;
      done_in  = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = idx_ff;
      wr_data  = val_ff;
      rd_en    = 1'b0;
      rd_addr  = parent;
      unique case (state_ff)
         H_IDLE: begin
            if (cmd.go) begin
               unique case (cmd.op)
                  OP_PUSH: begin
                     val_in   = cmd.value;
                     idx_in   = size_ff[AW-1:0];
                     size_in  = size_ff + 1'b1;
                     state_in = H_UP;
                  end
                  OP_POP: begin
                     res_in  = top_ff;
                     n_in    = last;
                     size_in = last;
                     if (size_ff <= (AW+1)'(1)) begin
                        done_in = 1'b1;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = last[AW-1:0];
                        state_in = H_DN_LAST;
                     end
                  end
                  OP_PUSHPOP: begin
                     if (size_ff == '0 || !ranks_above(top_ff, cmd.value, IS_MAX)) begin
                        res_in  = cmd.value;
                        done_in = 1'b1;
                     end else begin
                        res_in   = top_ff;
                        val_in   = cmd.value;
                        idx_in   = '0;
                        n_in     = size_ff;
                        state_in = H_DN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         H_UP: begin
            if (idx_ff == '0) begin
               wr_en    = 1'b1;
               done_in  = 1'b1;
               state_in = H_IDLE;
            end else begin
               rd_en    = 1'b1;
               state_in = H_UP_CMP;
            end
         end
         H_UP_CMP: begin
            wr_en = 1'b1;
            if (ranks_above(val_ff, rd_data, IS_MAX)) begin
               // parent moves down into the hole
               wr_data  = rd_data;
               idx_in   = parent;
               state_in = H_UP;
            end else begin
               done_in  = 1'b1;
               state_in = H_IDLE;
            end
         end
         H_DN_LAST: begin
            val_in   = rd_data;
            idx_in   = '0;
            state_in = H_DN;
         end
         H_DN: begin
            if (lft >= n_ext) begin
               wr_en    = 1'b1;
               done_in  = 1'b1;
               state_in = H_IDLE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = lft[AW-1:0];
               state_in = H_DN_L;
            end
         end
         H_DN_L: begin
            lch_in = rd_data;
            if (rgt < n_ext) begin
               rd_en    = 1'b1;
               rd_addr  = rgt[AW-1:0];
               state_in = H_DN_R;
            end else begin
               wr_en = 1'b1;
               if (ranks_above(rd_data, val_ff, IS_MAX)) begin
                  wr_data  = rd_data;
                  idx_in   = lft[AW-1:0];
                  state_in = H_DN;
               end else begin
                  done_in  = 1'b1;
                  state_in = H_IDLE;
               end
            end
         end
         H_DN_R: begin
            wr_en = 1'b1;
            if (ranks_above(rd_data, lch_ff, IS_MAX)) begin
               if (ranks_above(rd_data, val_ff, IS_MAX)) begin
                  wr_data  = rd_data;
                  idx_in   = rgt[AW-1:0];
                  state_in = H_DN;
               end else begin
                  done_in  = 1'b1;
                  state_in = H_IDLE;
               end
            end else begin
               if (ranks_above(lch_ff, val_ff, IS_MAX)) begin
                  wr_data  = lch_ff;
                  idx_in   = lft[AW-1:0];
                  state_in = H_DN;
               end else begin
                  done_in  = 1'b1;
                  state_in = H_IDLE;
               end
            end
         end
         default: state_in = H_IDLE;
      endcase
   end

   assign status.done   = done_ff;
   assign status.result = res_ff;
   assign status.top    = top_ff;
   assign size          = size_ff;

endmodule

/* design/running_median_two_heaps.sv */
// a sift-up visits H_UP and H_UP_CMP per heap level; a sift-down visits H_DN, H_DN_L and,
// with two children, H_DN_R per level; the worst case runs a push, a pop and a transfer before
// the result is registered; a word rejected with the store full goes straight to T_FIN
// throughput: one word at a time; the next word is taken once the result is registered
// the result register lets a new word in while the previous result waits
// synchronous active-high reset empties both heaps and clears the median; no clearing pass
module running_median_two_heaps #(
   parameter int HEAP_DEPTH = rmh_pkg::RMH_HEAP_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  rmh_pkg::sample_type           req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output rmh_pkg::median_type           rsp_median_doubled,
   output logic                          rsp_accepted,
   output logic [$clog2(HEAP_DEPTH)+1:0] rsp_sample_count
);
   import rmh_pkg::*;

   localparam int AW = $clog2(HEAP_DEPTH);
   localparam int CW = AW + 2;
   localparam logic [CW-1:0] FULL_COUNT = CW'(2 * HEAP_DEPTH);
   localparam logic [CW-1:0] DEPTH_C    = CW'(HEAP_DEPTH);

   ctrl_state_type  state_ff, state_in;
   logic            tgt_ff, tgt_in;
   logic            pp_ff, pp_in;
   logic            acc_ff, acc_in;
   median_type      med_ff, med_in;
   logic            rsp_valid_ff, rsp_valid_in;
   median_type      rsp_med_ff, rsp_med_in;
   logic            rsp_acc_ff, rsp_acc_in;
   logic [CW-1:0]   rsp_cnt_ff, rsp_cnt_in;

   heap_cmd_type    up_cmd, lo_cmd, tgt_cmd, oth_cmd;
   heap_status_type up_st, lo_st;
   logic [AW:0]     up_size, lo_size;
   logic [CW-1:0]   up_ext, lo_ext, total, tgt_size, oth_size;
   logic            to_upper, sel, tgt_done, oth_done;
   sample_type      tgt_res;
   median_type      med_new;

   rmh_heap #(.HEAP_DEPTH(HEAP_DEPTH), .IS_MAX(1'b0)) u_upper (
      .clock  (clock),
      .reset  (reset),
      .cmd    (up_cmd),
      .status (up_st),
      .size   (up_size)
   );

   rmh_heap #(.HEAP_DEPTH(HEAP_DEPTH), .IS_MAX(1'b1)) u_lower (
      .clock  (clock),
      .reset  (reset),
      .cmd    (lo_cmd),
      .status (lo_st),
      .size   (lo_size)
   );

   assign up_ext   = CW'(up_size);
   assign lo_ext   = CW'(lo_size);
   assign total    = up_ext + lo_ext;
   assign to_upper = (up_size == '0) || ($signed({req_sample, 1'b0}) > med_ff);
   assign sel      = (state_ff == T_IDLE) ? to_upper : tgt_ff;
   assign tgt_size = sel ? up_ext : lo_ext;
   assign oth_size = sel ? lo_ext : up_ext;
   assign tgt_done = tgt_ff ? up_st.done : lo_st.done;
   assign oth_done = tgt_ff ? lo_st.done : up_st.done;
   assign tgt_res  = tgt_ff ? up_st.result : lo_st.result;
   assign up_cmd   = sel ? tgt_cmd : oth_cmd;
   assign lo_cmd   = sel ? oth_cmd : tgt_cmd;

   always_comb begin
      if (up_size == lo_size && up_size != '0) begin
         med_new = MEDIAN_W'(up_st.top) + MEDIAN_W'(lo_st.top);
      end else if (up_size > lo_size) begin
         med_new = {up_st.top, 1'b0};
      end else if (lo_size != '0) begin
         med_new = {lo_st.top, 1'b0};
      end else begin
         med_new = med_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         med_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         med_ff       <= med_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      tgt_ff     <= tgt_in;
      pp_ff      <= pp_in;
      acc_ff     <= acc_in;
      rsp_med_ff <= rsp_med_in;
      rsp_acc_ff <= rsp_acc_in;
      rsp_cnt_ff <= rsp_cnt_in;
   end

   always_comb begin
      state_in     = state_ff;
      tgt_in       = tgt_ff;
      pp_in        = pp_ff;
      acc_in       = acc_ff;
      med_in       = med_ff;
      rsp_med_in   = rsp_med_ff;
      rsp_acc_in   = rsp_acc_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      tgt_cmd      = '{go: 1'b0, op: OP_PUSH, value: req_sample};
      oth_cmd      = '{go: 1'b0, op: OP_PUSH, value: tgt_res};
      unique case (state_ff)
         T_IDLE: begin
            if (req_valid) begin
               if (total == FULL_COUNT) begin
                  acc_in   = 1'b0;
                  state_in = T_FIN;
               end else begin
                  acc_in      = 1'b1;
                  tgt_in      = to_upper;
                  pp_in       = (tgt_size >= DEPTH_C);
                  tgt_cmd.go  = 1'b1;
                  tgt_cmd.op  = (tgt_size >= DEPTH_C) ? OP_PUSHPOP : OP_PUSH;
                  state_in    = T_OP1;
               end
            end
         end
         T_OP1: begin
            if (tgt_done) begin
               if (pp_ff) begin
                  oth_cmd.go = 1'b1;
                  state_in   = T_XFER;
               end else if (tgt_size > oth_size + 1'b1) begin
                  tgt_cmd.go = 1'b1;
                  tgt_cmd.op = OP_POP;
                  state_in   = T_POP;
               end else begin
                  state_in = T_FIN;
               end
            end
         end
         T_POP: begin
            if (tgt_done) begin
               oth_cmd.go = 1'b1;
               state_in   = T_XFER;
            end
         end
         T_XFER: begin
            if (oth_done) begin
               state_in = T_FIN;
            end
         end
         T_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               if (acc_ff) begin
                  med_in     = med_new;
                  rsp_med_in = med_new;
               end else begin
                  rsp_med_in = med_ff;
               end
               rsp_acc_in   = acc_ff;
               rsp_cnt_in   = total;
               rsp_valid_in = 1'b1;
               state_in     = T_IDLE;
            end
         end
         default: state_in = T_IDLE;
      endcase
   end

   assign req_stall          = (state_ff != T_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_median_doubled = rsp_med_ff;
   assign rsp_accepted       = rsp_acc_ff;
   assign rsp_sample_count   = rsp_cnt_ff;

endmodule

/* design/rmh_check.sv */
module rmh_check #(
   parameter int HEAP_DEPTH = rmh_pkg::RMH_HEAP_DEPTH
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input rmh_pkg::median_type           rsp_median_doubled,
   input logic                          rsp_accepted,
   input logic [$clog2(HEAP_DEPTH)+1:0] rsp_sample_count
);

   localparam int CW = $clog2(HEAP_DEPTH) + 2;
   localparam logic [CW-1:0] FULL_COUNT = CW'(2 * HEAP_DEPTH);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word present after reset");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second word taken while one is in work");

   a_reject_only_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_accepted |-> rsp_sample_count == FULL_COUNT)
      else $error("sample dropped while store not full");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_sample_count <= FULL_COUNT && rsp_sample_count != '0)
      else $error("sample count out of range");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_median_doubled))
      else $error("stalled result word changed");

endmodule

bind running_median_two_heaps rmh_check #(.HEAP_DEPTH(HEAP_DEPTH)) u_rmh_check (.*);

/* test/running_median_two_heaps_tb.sv */
`timescale 1ns / 100ps

module running_median_two_heaps_tb;
   import rmh_pkg::*;

   localparam int DEPTH   = RMH_HEAP_DEPTH;
   localparam int CNT_W   = $clog2(DEPTH) + 2;
   localparam int N_RAND  = 1580;
   localparam int LOW_K   = 0;   // max-heap of the smaller half
   localparam int HIGH_K  = 1;   // min-heap of the larger half

   typedef struct {
      sample_type sample;
      bit         drain_first;
   } word_type;

   typedef struct {
      median_type       median_doubled;
      logic             accepted;
      logic [CNT_W-1:0] sample_count;
   } median_result_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   sample_type       req_sample = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   median_type       rsp_median_doubled;
   logic             rsp_accepted;
   logic [CNT_W-1:0] rsp_sample_count;

   word_type          pending_words[$];
   median_result_type expected_medians[$];

   int     heap_mem[2][DEPTH];
   int     heap_len[2];
   longint median_x2;

   int n_sent, n_checked, n_errors, n_rejected;
   bit stimulus_done;

   running_median_two_heaps u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample         (req_sample),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_median_doubled (rsp_median_doubled),
      .rsp_accepted       (rsp_accepted),
      .rsp_sample_count   (rsp_sample_count)
   );

   always #2 clock = ~clock;

   function automatic bit ranks_higher(int a, int b, int k);
      return (k == LOW_K) ? (a > b) : (a < b);
   endfunction

   function automatic void heap_swap(int k, int i, int j);
      int t;
      t = heap_mem[k][i];
      heap_mem[k][i] = heap_mem[k][j];
      heap_mem[k][j] = t;
   endfunction

   function automatic void heap_sift_down(int k, int n);
      int i, l, c;
      i = 0;
      forever begin
         l = 2 * i + 1;
         if (l >= n) break;
         c = l;
         if (l + 1 < n && ranks_higher(heap_mem[k][l+1], heap_mem[k][l], k)) c = l + 1;
         if (!ranks_higher(heap_mem[k][c], heap_mem[k][i], k)) break;
         heap_swap(k, c, i);
         i = c;
      end
   endfunction

   function automatic void heap_push(int k, int v);
      int i, p;
      if (heap_len[k] >= DEPTH) return;
      i = heap_len[k];
      heap_mem[k][i] = v;
      while (i > 0) begin
         p = (i - 1) / 2;
         if (!ranks_higher(heap_mem[k][i], heap_mem[k][p], k)) break;
         heap_swap(k, i, p);
         i = p;
      end
      heap_len[k]++;
   endfunction

   function automatic int heap_pop(int k);
      int top;
      top = heap_mem[k][0];
      heap_len[k]--;
      heap_mem[k][0] = heap_mem[k][heap_len[k]];
      heap_sift_down(k, heap_len[k]);
      return top;
   endfunction

   function automatic int heap_pushpop(int k, int v);
      int top;
      if (heap_len[k] == 0 || !ranks_higher(heap_mem[k][0], v, k)) return v;
      top = heap_mem[k][0];
      heap_mem[k][0] = v;
      heap_sift_down(k, heap_len[k]);
      return top;
   endfunction

   function automatic median_result_type add_sample(sample_type s);
      median_result_type r;
      int k, o;
      r.accepted = 1'b0;
      if (heap_len[LOW_K] + heap_len[HIGH_K] < 2 * DEPTH) begin
         r.accepted = 1'b1;
         k = (heap_len[HIGH_K] == 0 || longint'(s) * 2 > median_x2) ? HIGH_K : LOW_K;
         o = (k == HIGH_K) ? LOW_K : HIGH_K;
         if (heap_len[k] >= DEPTH) begin
            // full side: swap the word against its top, spill to the other side
            heap_push(o, heap_pushpop(k, s));
         end else begin
            heap_push(k, s);
            if (heap_len[k] > heap_len[o] + 1) heap_push(o, heap_pop(k));
         end
         if (heap_len[HIGH_K] == heap_len[LOW_K] && heap_len[HIGH_K] > 0)
            median_x2 = longint'(heap_mem[HIGH_K][0]) + longint'(heap_mem[LOW_K][0]);
         else if (heap_len[HIGH_K] > heap_len[LOW_K])
            median_x2 = longint'(heap_mem[HIGH_K][0]) * 2;
         else if (heap_len[LOW_K] > 0)
            median_x2 = longint'(heap_mem[LOW_K][0]) * 2;
      end
      r.median_doubled = median_x2[MEDIAN_W-1:0];
      r.sample_count   = CNT_W'(heap_len[LOW_K] + heap_len[HIGH_K]);
      return r;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // repeated values so ties against the median come up often
   function automatic sample_type median_hint(int i);
      return sample_type'((i % 7) - 3);
   endfunction

   // driver
   int  send_gap;
   bit  send_quiet;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_medians.insert(expected_medians.size(), add_sample(req_sample));
            n_sent++;
            send_quiet = ((n_sent / 200) % 4) == 3;
            send_gap = send_quiet ? 0 : pick_gap();
         end
         if (!(req_valid && req_stall)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_words.size() > 0 &&
                         !(pending_words[0].drain_first && expected_medians.size() > 0)) begin
               req_valid  <= 1'b1;
               req_sample <= pending_words[0].sample;
               void'(pending_words.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   int stall_left;
   bit long_hold_done;
   always @(posedge clock) begin
      median_result_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_medians.size() == 0) begin
               n_errors++;
               if (n_errors <= 10) $display("unexpected result word at %0t", $realtime);
            end else begin
               e = expected_medians.pop_front();
               if (rsp_median_doubled !== e.median_doubled || rsp_accepted !== e.accepted ||
                   rsp_sample_count !== e.sample_count) begin
                  n_errors++;
                  if (n_errors <= 10)
                     $display("result %0d: expected median2=%0d acc=%0b cnt=%0d, got %0d %0b %0d",
                              n_checked, e.median_doubled, e.accepted, e.sample_count,
                              rsp_median_doubled, rsp_accepted, rsp_sample_count);
               end
               if (!e.accepted) n_rejected++;
               n_checked++;
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!long_hold_done && n_checked == 150) begin
            // long hold while the sender keeps offering, fills the block
            long_hold_done = 1;
            stall_left = 400;
            rsp_stall <= 1'b1;
         end else if (((n_checked / 250) % 3) == 2 || $urandom_range(0, 99) < 70) begin
            rsp_stall <= 1'b0;
         end else begin
            stall_left = pick_gap();
            rsp_stall <= 1'b1;
         end
      end
   end

   task automatic queue_word(sample_type s, bit drain);
      word_type w;
      w.sample = s;
      w.drain_first = drain;
      pending_words.insert(pending_words.size(), w);
   endtask

   initial begin
      int r;
      sample_type s;
      heap_len[LOW_K] = 0;
      heap_len[HIGH_K] = 0;
      median_x2 = 0;
      // directed: extremes, ties, a first word into the empty upper side
      queue_word(32'sh7fffffff, 0);
      queue_word(32'sh80000000, 0);
      queue_word(32'sh7fffffff, 0);
      queue_word(32'sh80000000, 0);
      queue_word(0, 0);
      queue_word(-1, 0);
      queue_word(1, 0);
      queue_word(0, 0);
      queue_word(0, 0);
      queue_word(32'sh7ffffffe, 0);
      queue_word(32'sh80000001, 0);
      queue_word(5, 0);
      queue_word(5, 0);
      queue_word(5, 0);
      queue_word(-5, 0);
      queue_word(32'sh55555555, 0);
      queue_word(32'shaaaaaaaa, 0);
      queue_word(3, 0);
      queue_word(4, 0);
      queue_word(-2, 0);
      for (int i = 0; i < N_RAND; i++) begin
         r = $urandom_range(0, 99);
         if (r < 40)      s = $urandom;
         else if (r < 70) s = $urandom_range(0, 64) - 32;
         else if (r < 80) s = (r & 1) ? 32'sh7fffffff - $urandom_range(0, 3)
                                      : 32'sh80000000 + $urandom_range(0, 3);
         else if (r < 90) s = median_hint(i);
         else             s = $urandom_range(0, 2000) * 1000 - 1000000;
         queue_word(s, i == 400);
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      wait (pending_words.size() == 0 && !req_valid);
      wait (expected_medians.size() == 0);
      repeat (200) @(posedge clock);
      $display("%0d samples sent, %0d results checked, %0d rejected with the store full",
               n_sent, n_checked, n_rejected);
      if (n_errors == 0 && expected_medians.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #4000000;
      $display("timeout with %0d results outstanding", expected_medians.size());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

/* sim.f */
design/rmh_pkg.sv
design/rmh_ram.sv
design/rmh_heap.sv
design/running_median_two_heaps.sv
design/rmh_check.sv
test/running_median_two_heaps_tb.sv
